// File: rtl/hfrq_pkg.sv
// ----------------------------------------------------------------------------
// hfrq_pkg
// Shared constants for the ready-queue scheduler: operation and status
// codes, configuration register indexes, field widths and stream layouts.
// ----------------------------------------------------------------------------
package hfrq_pkg;

    // Default number of queue slots.
    localparam int QUEUE_DEPTH_DEF = 16;

    // Field widths.
    localparam int OP_W     = 2;
    localparam int PID_W    = 16;
    localparam int EST_W    = 16;
    localparam int TIME_W   = 32;
    localparam int OCC_W    = 5;
    localparam int STATUS_W = 2;
    localparam int ALPHA_W  = 9;
    localparam int CFG_IDX_W = 1;

    // Input stream data layout (tuser carries the operation code).
    localparam int S_PID_LSB   = 0;
    localparam int S_EST_LSB   = 16;
    localparam int S_REAL_LSB  = 32;
    localparam int S_REEST_BIT = 48;
    localparam int S_TDATA_W   = 56;

    // Output stream data layout (tuser carries the status code).
    localparam int M_PID_LSB = 0;
    localparam int M_EST_LSB = 16;
    localparam int M_OCC_LSB = 32;
    localparam int M_TDATA_W = 40;
    localparam int M_PAD_W   = M_TDATA_W - M_OCC_LSB - OCC_W;

    // Operation codes.
    localparam logic [OP_W-1:0] OP_ENQUEUE = 2'd0;
    localparam logic [OP_W-1:0] OP_DEQUEUE = 2'd1;
    localparam logic [OP_W-1:0] OP_TICK    = 2'd2;

    // Status codes.
    localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd2;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_POLICY_MODE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_ALPHA       = 1'b1;

    // Selection policies.
    localparam logic MODE_FIFO = 1'b0;
    localparam logic MODE_HRRN = 1'b1;

    // Smoothing weight: one in Q1.8, and the value after reset.
    localparam logic [ALPHA_W-1:0] ALPHA_ONE   = 9'd256;
    localparam logic [ALPHA_W-1:0] ALPHA_RESET = 9'd128;

endpackage

// File: rtl/hfrq_ram.sv
// ----------------------------------------------------------------------------
// hfrq_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module hfrq_ram #(
    parameter int WIDTH = 96,
    parameter int DEPTH = 16,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

// File: rtl/hrrn_fifo_ready_queue_top.sv
// ----------------------------------------------------------------------------
// hrrn_fifo_ready_queue_top
// Ready-queue scheduler with first-in-first-out or highest-response-ratio-
// next selection, driven by enqueue, dequeue and tick transactions.
// ----------------------------------------------------------------------------
// Every input transaction yields one result transaction. The block takes one
// transaction at a time and drops s_tready until its result is in the output
// register. A tick or unused code goes straight to the result. An enqueue
// searches the slots in order for the lowest free one, after the smoothing
// states when the estimate is re-estimated (one shared 33x16 multiplier, used
// twice); a dropped enqueue skips the slot search. A dequeue visits every slot
// in turn through the slot RAM read port, loads each waiting process it finds
// and compares it with the best so far, directly in FIFO mode or, in HRRN mode,
// after the shared multiplier forms two cross products for the ratio compare.
// A dequeue on an empty queue goes straight to the result.
module hrrn_fifo_ready_queue_top #(
    parameter int QUEUE_DEPTH = hfrq_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    // Configuration write port
    input  logic                               cfg_wr_en,
    input  logic [hfrq_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [hfrq_pkg::ALPHA_W-1:0]       cfg_wr_data,
    // Input stream
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // pid[15:0], burst_estimate[31:16], real_run_time[47:32], reestimate[48]
    input  logic [hfrq_pkg::S_TDATA_W-1:0]     s_tdata,
    // op[1:0]
    input  logic [hfrq_pkg::OP_W-1:0]          s_tuser,
    // Output stream
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // pid_out[15:0], estimate_out[31:16], occupancy[36:32]
    output logic [hfrq_pkg::M_TDATA_W-1:0]     m_tdata,
    // status[1:0]
    output logic [hfrq_pkg::STATUS_W-1:0]      m_tuser
);

    localparam int IDX_W  = $clog2(QUEUE_DEPTH);
    localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);
    localparam int SUM_W  = hfrq_pkg::TIME_W + 1;
    localparam int PROD_W = SUM_W + hfrq_pkg::EST_W;
    localparam int ACC_W  = hfrq_pkg::EST_W + hfrq_pkg::ALPHA_W;

    // One slot record as stored in the RAM.
    typedef struct packed {
        logic [hfrq_pkg::TIME_W-1:0] order;
        logic [hfrq_pkg::TIME_W-1:0] arrival;
        logic [hfrq_pkg::EST_W-1:0]  est;
        logic [hfrq_pkg::PID_W-1:0]  pid;
    } slot_t;

    typedef enum logic [10:0] {
        S_IDLE     = 11'b000_0000_0001,
        S_SMOOTH_A = 11'b000_0000_0010,
        S_SMOOTH_B = 11'b000_0000_0100,
        S_FIND     = 11'b000_0000_1000,
        S_READ     = 11'b000_0001_0000,
        S_LOAD     = 11'b000_0010_0000,
        S_MUL_A    = 11'b000_0100_0000,
        S_MUL_B    = 11'b000_1000_0000,
        S_CMP      = 11'b001_0000_0000,
        S_FINISH   = 11'b010_0000_0000,
        S_DONE     = 11'b100_0000_0000
    } state_t;

    // Control registers
    state_t                          state_reg, state_next;
    logic                            policy_reg, policy_next;
    logic [hfrq_pkg::ALPHA_W-1:0]    alpha_reg, alpha_next;
    logic [QUEUE_DEPTH-1:0]          valid_reg, valid_next;
    logic [CNT_W-1:0]                count_reg, count_next;
    logic [hfrq_pkg::TIME_W-1:0]     time_reg, time_next;
    logic [hfrq_pkg::TIME_W-1:0]     order_reg, order_next;
    logic [IDX_W-1:0]                scan_reg, scan_next;
    logic                            have_best_reg, have_best_next;
    logic                            m_tvalid_reg, m_tvalid_next;

    // Payload registers
    logic [hfrq_pkg::PID_W-1:0]      pid_reg;
    logic [hfrq_pkg::EST_W-1:0]      est_reg;
    logic [hfrq_pkg::EST_W-1:0]      real_reg;
    logic [ACC_W-1:0]                acc_reg;
    logic [SUM_W-1:0]                cur_sum_reg;
    logic [hfrq_pkg::EST_W-1:0]      cur_eff_reg;
    logic [hfrq_pkg::EST_W-1:0]      cur_est_reg;
    logic [hfrq_pkg::PID_W-1:0]      cur_pid_reg;
    logic [hfrq_pkg::TIME_W-1:0]     cur_age_reg;
    logic [IDX_W-1:0]                best_idx_reg;
    logic [SUM_W-1:0]                best_sum_reg;
    logic [hfrq_pkg::EST_W-1:0]      best_eff_reg;
    logic [hfrq_pkg::EST_W-1:0]      best_est_reg;
    logic [hfrq_pkg::PID_W-1:0]      best_pid_reg;
    logic [hfrq_pkg::TIME_W-1:0]     best_age_reg;
    logic [PROD_W-1:0]               prod_a_reg;
    logic [PROD_W-1:0]               prod_b_reg;
    logic [hfrq_pkg::STATUS_W-1:0]   res_status_reg;
    logic [hfrq_pkg::PID_W-1:0]      res_pid_reg;
    logic [hfrq_pkg::EST_W-1:0]      res_est_reg;
    logic [hfrq_pkg::STATUS_W-1:0]   m_tuser_reg;
    logic [hfrq_pkg::M_TDATA_W-1:0]  m_tdata_reg;

    // Input fields
    logic [hfrq_pkg::OP_W-1:0]       in_op;
    logic [hfrq_pkg::PID_W-1:0]      in_pid;
    logic [hfrq_pkg::EST_W-1:0]      in_est;
    logic [hfrq_pkg::EST_W-1:0]      in_real;
    logic                            in_reest;

    // Datapath signals
    logic                            queue_full;
    logic                            queue_empty;
    logic                            scan_last;
    logic                            out_free;
    logic                            slot_free;
    logic [hfrq_pkg::ALPHA_W-1:0]    alpha_eff;
    logic [SUM_W-1:0]                mul_a;
    logic [hfrq_pkg::EST_W-1:0]      mul_b;
    logic [PROD_W-1:0]               mul_p;
    logic [ACC_W-1:0]                smooth_sum;
    slot_t                           ram_wr_data;
    logic [$bits(slot_t)-1:0]        ram_rd_data;
    slot_t                           rd_slot;
    logic [hfrq_pkg::TIME_W-1:0]     ld_wait;
    logic [hfrq_pkg::EST_W-1:0]      ld_eff;
    logic [SUM_W-1:0]                ld_sum;
    logic [hfrq_pkg::TIME_W-1:0]     ld_age;
    logic                            cand_wins;
    logic [CNT_W+hfrq_pkg::OCC_W-1:0] count_ext;

    assign in_op    = s_tuser;
    assign in_pid   = s_tdata[hfrq_pkg::S_PID_LSB +: hfrq_pkg::PID_W];
    assign in_est   = s_tdata[hfrq_pkg::S_EST_LSB +: hfrq_pkg::EST_W];
    assign in_real  = s_tdata[hfrq_pkg::S_REAL_LSB +: hfrq_pkg::EST_W];
    assign in_reest = s_tdata[hfrq_pkg::S_REEST_BIT];

    assign queue_full  = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign queue_empty = (count_reg == '0);
    assign scan_last   = (scan_reg == IDX_W'(QUEUE_DEPTH - 1));
    assign out_free    = !m_tvalid_reg || m_tready;
    assign slot_free   = !valid_reg[scan_reg];
    assign alpha_eff   = (alpha_reg > hfrq_pkg::ALPHA_ONE) ? hfrq_pkg::ALPHA_ONE : alpha_reg;

    // Shared multiplier: smoothing products, then the ratio cross products.
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        unique case (state_reg)
            S_SMOOTH_A:
            begin
                mul_a = SUM_W'(est_reg);
                mul_b = hfrq_pkg::EST_W'(alpha_eff);
            end
            S_SMOOTH_B:
            begin
                mul_a = SUM_W'(real_reg);
                mul_b = hfrq_pkg::EST_W'(hfrq_pkg::ALPHA_ONE - alpha_eff);
            end
            S_MUL_A:
            begin
                mul_a = cur_sum_reg;
                mul_b = best_eff_reg;
            end
            S_MUL_B:
            begin
                mul_a = best_sum_reg;
                mul_b = cur_eff_reg;
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p      = PROD_W'(mul_a) * PROD_W'(mul_b);
    assign smooth_sum = acc_reg + mul_p[ACC_W-1:0];

    // Slot storage
    assign ram_wr_data.order   = order_reg;
    assign ram_wr_data.arrival = time_reg;
    assign ram_wr_data.est     = est_reg;
    assign ram_wr_data.pid     = pid_reg;

    hfrq_ram #(
        .WIDTH ($bits(slot_t)),
        .DEPTH (QUEUE_DEPTH)
    ) u_slot_ram (
        .clk     (clk),
        .wr_en   ((state_reg == S_FIND) && slot_free),
        .wr_addr (scan_reg),
        .wr_data (ram_wr_data),
        .rd_addr (scan_reg),
        .rd_data (ram_rd_data)
    );

    // Wait plus effective estimate, and age, of the slot just read.
    assign rd_slot = slot_t'(ram_rd_data);
    assign ld_wait = time_reg - rd_slot.arrival;
    assign ld_eff  = (rd_slot.est == '0) ? hfrq_pkg::EST_W'(1) : rd_slot.est;
    assign ld_sum  = SUM_W'(ld_wait) + SUM_W'(ld_eff);
    assign ld_age  = order_reg - rd_slot.order;

    // The candidate replaces the best one on a larger ratio, or on an equal
    // ratio when it is newer; in FIFO mode the older one wins.
    assign cand_wins = (policy_reg == hfrq_pkg::MODE_HRRN) ?
                       ((prod_a_reg > prod_b_reg) ||
                        ((prod_a_reg == prod_b_reg) && (cur_age_reg < best_age_reg))) :
                       (cur_age_reg > best_age_reg);

    // Control next state
    always_comb
    begin
        state_next     = state_reg;
        policy_next    = policy_reg;
        alpha_next     = alpha_reg;
        valid_next     = valid_reg;
        count_next     = count_reg;
        time_next      = time_reg;
        order_next     = order_reg;
        scan_next      = scan_reg;
        have_best_next = have_best_reg;
        m_tvalid_next  = m_tvalid_reg;

        if (cfg_wr_en)
        begin
            unique case (cfg_index)
                hfrq_pkg::CFG_POLICY_MODE: policy_next = cfg_wr_data[0];
                hfrq_pkg::CFG_ALPHA:       alpha_next  = cfg_wr_data;
            endcase
        end

        if (m_tvalid_reg && m_tready)
        begin
            m_tvalid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    scan_next      = '0;
                    have_best_next = 1'b0;
                    unique case (in_op)
                        hfrq_pkg::OP_ENQUEUE:
                        begin
                            if (in_reest)
                                state_next = S_SMOOTH_A;
                            else if (queue_full)
                                state_next = S_DONE;
                            else
                                state_next = S_FIND;
                        end
                        hfrq_pkg::OP_DEQUEUE:
                        begin
                            state_next = queue_empty ? S_DONE : S_READ;
                        end
                        hfrq_pkg::OP_TICK:
                        begin
                            time_next  = time_reg + 1'b1;
                            state_next = S_DONE;
                        end
                        default:
                        begin
                            state_next = S_DONE;
                        end
                    endcase
                end
            end
            S_SMOOTH_A:
            begin
                state_next = S_SMOOTH_B;
            end
            S_SMOOTH_B:
            begin
                state_next = queue_full ? S_DONE : S_FIND;
            end
            S_FIND:
            begin
                // The queue is not full here, so a free slot is always found.
                if (slot_free)
                begin
                    valid_next[scan_reg] = 1'b1;
                    count_next           = count_reg + 1'b1;
                    order_next           = order_reg + 1'b1;
                    state_next           = S_DONE;
                end
                else
                begin
                    scan_next = scan_reg + 1'b1;
                end
            end
            S_READ:
            begin
                if (!slot_free)
                    state_next = S_LOAD;
                else if (scan_last)
                    state_next = S_FINISH;
                else
                    scan_next = scan_reg + 1'b1;
            end
            S_LOAD:
            begin
                if (!have_best_reg)
                begin
                    have_best_next = 1'b1;
                    if (scan_last)
                    begin
                        state_next = S_FINISH;
                    end
                    else
                    begin
                        scan_next  = scan_reg + 1'b1;
                        state_next = S_READ;
                    end
                end
                else if (policy_reg == hfrq_pkg::MODE_HRRN)
                begin
                    state_next = S_MUL_A;
                end
                else
                begin
                    state_next = S_CMP;
                end
            end
            S_MUL_A:
            begin
                state_next = S_MUL_B;
            end
            S_MUL_B:
            begin
                state_next = S_CMP;
            end
            S_CMP:
            begin
                if (scan_last)
                begin
                    state_next = S_FINISH;
                end
                else
                begin
                    scan_next  = scan_reg + 1'b1;
                    state_next = S_READ;
                end
            end
            S_FINISH:
            begin
                valid_next[best_idx_reg] = 1'b0;
                count_next               = count_reg - 1'b1;
                state_next               = S_DONE;
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    m_tvalid_next = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            policy_reg    <= hfrq_pkg::MODE_FIFO;
            alpha_reg     <= hfrq_pkg::ALPHA_RESET;
            valid_reg     <= '0;
            count_reg     <= '0;
            time_reg      <= '0;
            order_reg     <= '0;
            scan_reg      <= '0;
            have_best_reg <= 1'b0;
            m_tvalid_reg  <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            policy_reg    <= policy_next;
            alpha_reg     <= alpha_next;
            valid_reg     <= valid_next;
            count_reg     <= count_next;
            time_reg      <= time_next;
            order_reg     <= order_next;
            scan_reg      <= scan_next;
            have_best_reg <= have_best_next;
            m_tvalid_reg  <= m_tvalid_next;
        end
    end

    assign count_ext = (CNT_W + hfrq_pkg::OCC_W)'(count_reg);

    // Payload registers
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    pid_reg  <= in_pid;
                    est_reg  <= in_est;
                    real_reg <= in_real;
                    unique case (in_op)
                        hfrq_pkg::OP_ENQUEUE:
                        begin
                            res_status_reg <= queue_full ? hfrq_pkg::STATUS_FULL
                                                         : hfrq_pkg::STATUS_OK;
                            res_pid_reg    <= in_pid;
                            res_est_reg    <= in_est;
                        end
                        hfrq_pkg::OP_DEQUEUE:
                        begin
                            res_status_reg <= queue_empty ? hfrq_pkg::STATUS_EMPTY
                                                          : hfrq_pkg::STATUS_OK;
                            res_pid_reg    <= '0;
                            res_est_reg    <= '0;
                        end
                        default:
                        begin
                            res_status_reg <= hfrq_pkg::STATUS_OK;
                            res_pid_reg    <= '0;
                            res_est_reg    <= '0;
                        end
                    endcase
                end
            end
            S_SMOOTH_A:
            begin
                acc_reg <= mul_p[ACC_W-1:0];
            end
            S_SMOOTH_B:
            begin
                est_reg     <= smooth_sum[8 +: hfrq_pkg::EST_W];
                res_est_reg <= smooth_sum[8 +: hfrq_pkg::EST_W];
            end
            S_LOAD:
            begin
                cur_sum_reg <= ld_sum;
                cur_eff_reg <= ld_eff;
                cur_est_reg <= rd_slot.est;
                cur_pid_reg <= rd_slot.pid;
                cur_age_reg <= ld_age;
                if (!have_best_reg)
                begin
                    best_idx_reg <= scan_reg;
                    best_sum_reg <= ld_sum;
                    best_eff_reg <= ld_eff;
                    best_est_reg <= rd_slot.est;
                    best_pid_reg <= rd_slot.pid;
                    best_age_reg <= ld_age;
                end
            end
            S_MUL_A:
            begin
                prod_a_reg <= mul_p;
            end
            S_MUL_B:
            begin
                prod_b_reg <= mul_p;
            end
            S_CMP:
            begin
                if (cand_wins)
                begin
                    best_idx_reg <= scan_reg;
                    best_sum_reg <= cur_sum_reg;
                    best_eff_reg <= cur_eff_reg;
                    best_est_reg <= cur_est_reg;
                    best_pid_reg <= cur_pid_reg;
                    best_age_reg <= cur_age_reg;
                end
            end
            S_FINISH:
            begin
                res_pid_reg <= best_pid_reg;
                res_est_reg <= best_est_reg;
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    m_tuser_reg <= res_status_reg;
                    m_tdata_reg <= {{hfrq_pkg::M_PAD_W{1'b0}},
                                    count_ext[hfrq_pkg::OCC_W-1:0],
                                    res_est_reg, res_pid_reg};
                end
            end
            default:
            begin
            end
        endcase
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

endmodule

// File: rtl/hfrq_checker.sv
// ----------------------------------------------------------------------------
// hfrq_checker
// Port-level assertions for the ready-queue scheduler, bound to the top level.
// ----------------------------------------------------------------------------
module hfrq_checker #(
    parameter int QUEUE_DEPTH = hfrq_pkg::QUEUE_DEPTH_DEF
) (
    input logic                              clk,
    input logic                              rst_n,
    input logic                              s_tvalid,
    input logic                              s_tready,
    input logic                              m_tvalid,
    input logic                              m_tready,
    input logic [hfrq_pkg::M_TDATA_W-1:0]    m_tdata,
    input logic [hfrq_pkg::STATUS_W-1:0]     m_tuser
);

    localparam int OCC_W = hfrq_pkg::OCC_W;
    localparam logic [OCC_W-1:0] FULL_OCC = OCC_W'(QUEUE_DEPTH);

    // One transaction at a time: the input side closes after each accept.
    assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
    else $error("input accepted while a transaction was in progress");

    // A dequeue on an empty queue reports nothing and an empty queue.
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && (m_tuser == hfrq_pkg::STATUS_EMPTY)) |-> (m_tdata == '0))
    else $error("empty-queue result carries data");

    // A dropped enqueue happens only with every slot taken.
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && (m_tuser == hfrq_pkg::STATUS_FULL)) |->
        (m_tdata[hfrq_pkg::M_OCC_LSB +: OCC_W] == FULL_OCC))
    else $error("full status with free slots");

    // A stalled result holds.
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
    else $error("result changed while stalled");

endmodule

bind hrrn_fifo_ready_queue_top hfrq_checker #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
) u_hfrq_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

// File: tb/sv/hfrq_sched_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// hfrq_sched_checker
// Watches the configuration port and both streams of the ready-queue
// scheduler. It keeps its own copy of the queue, predicts one result per
// accepted input transaction and compares each result transaction with the
// oldest prediction, field by field.
// ----------------------------------------------------------------------------
module hfrq_sched_checker
    import hfrq_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]   cfg_index,
    input  logic [ALPHA_W-1:0]     cfg_wr_data,
    input  logic                   s_tvalid,
    input  logic                   s_tready,
    input  logic [S_TDATA_W-1:0]   s_tdata,
    input  logic [OP_W-1:0]        s_tuser,
    input  logic                   m_tvalid,
    input  logic                   m_tready,
    input  logic [M_TDATA_W-1:0]   m_tdata,
    input  logic [STATUS_W-1:0]    m_tuser,
    output int                     mismatches,
    output int                     pending
);

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [PID_W-1:0]    pid;
        logic [EST_W-1:0]    est;
        logic [OCC_W-1:0]    occ;
    } sched_result_t;

    // Shadow copy of the scheduler state.
    logic                 policy;
    logic [ALPHA_W-1:0]   alpha;
    bit                   slot_busy    [DEPTH];
    logic [PID_W-1:0]     slot_pid     [DEPTH];
    logic [EST_W-1:0]     slot_est     [DEPTH];
    logic [TIME_W-1:0]    slot_arrival [DEPTH];
    logic [31:0]          slot_seq     [DEPTH];
    logic [TIME_W-1:0]    now_ticks;
    logic [31:0]          seq_next;

    sched_result_t        results_due[$];
    sched_result_t        got;
    sched_result_t        want;
    int                   err_count;

    function automatic int waiting_count();
        int n;
        n = 0;
        for (int i = 0; i < DEPTH; i++)
        begin
            if (slot_busy[i])
                n++;
        end
        return n;
    endfunction

    // Exponential average: alpha weights the old estimate, clamped to one.
    function automatic logic [EST_W-1:0] smoothed_estimate(logic [EST_W-1:0] old_est,
                                                           logic [EST_W-1:0] run_time);
        logic [31:0] a;
        logic [31:0] acc;
        a   = (alpha > ALPHA_ONE) ? 32'd256 : 32'(alpha);
        acc = a * old_est + (32'd256 - a) * run_time;
        return acc[8 +: EST_W];
    endfunction

    function automatic logic [31:0] queue_age(int i);
        return seq_next - slot_seq[i];
    endfunction

    // True when the newer slot's response ratio is at least the best one's.
    function automatic bit newer_wins(int i, int b);
        logic [63:0] ei, eb, wi, wb;
        logic [31:0] di, db;
        ei = (slot_est[i] == '0) ? 64'd1 : {48'd0, slot_est[i]};
        eb = (slot_est[b] == '0) ? 64'd1 : {48'd0, slot_est[b]};
        di = now_ticks - slot_arrival[i];
        db = now_ticks - slot_arrival[b];
        wi = {32'd0, di};
        wb = {32'd0, db};
        return (wi + ei) * eb >= (wb + eb) * ei;
    endfunction

    // Applies one request to the shadow queue and returns its result.
    function automatic sched_result_t apply_request(logic [OP_W-1:0] op,
                                                    logic [S_TDATA_W-1:0] data);
        sched_result_t    r;
        logic [EST_W-1:0] est;
        int               slot, best, pick, n;
        bit               done [DEPTH];
        r = '0;
        case (op)
            OP_ENQUEUE:
            begin
                est = data[S_EST_LSB +: EST_W];
                if (data[S_REEST_BIT])
                    est = smoothed_estimate(est, data[S_REAL_LSB +: EST_W]);
                r.pid = data[S_PID_LSB +: PID_W];
                r.est = est;
                slot  = -1;
                for (int i = 0; i < DEPTH; i++)
                begin
                    if (!slot_busy[i] && slot < 0)
                        slot = i;
                end
                if (slot < 0)
                    r.status = STATUS_FULL;
                else
                begin
                    slot_busy[slot]    = 1'b1;
                    slot_pid[slot]     = r.pid;
                    slot_est[slot]     = est;
                    slot_arrival[slot] = now_ticks;
                    slot_seq[slot]     = seq_next;
                    seq_next           = seq_next + 1;
                end
            end
            OP_DEQUEUE:
            begin
                n = waiting_count();
                if (n == 0)
                    r.status = STATUS_EMPTY;
                else
                begin
                    // Visit waiting processes from oldest to newest.
                    best = -1;
                    for (int i = 0; i < DEPTH; i++)
                        done[i] = 1'b0;
                    for (int k = 0; k < n; k++)
                    begin
                        pick = -1;
                        for (int i = 0; i < DEPTH; i++)
                        begin
                            if (slot_busy[i] && !done[i] &&
                                (pick < 0 || queue_age(i) > queue_age(pick)))
                                pick = i;
                        end
                        done[pick] = 1'b1;
                        if (best < 0)
                            best = pick;
                        else if (policy == MODE_HRRN && newer_wins(pick, best))
                            best = pick;
                        if (policy == MODE_FIFO)
                            break;
                    end
                    r.pid           = slot_pid[best];
                    r.est           = slot_est[best];
                    slot_busy[best] = 1'b0;
                end
            end
            OP_TICK:
                now_ticks = now_ticks + 1;
            default:
                ;
        endcase
        r.occ = OCC_W'(waiting_count());
        return r;
    endfunction

    // Track configuration and both streams at every rising edge.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            policy    = MODE_FIFO;
            alpha     = ALPHA_RESET;
            now_ticks = '0;
            seq_next  = '0;
            for (int i = 0; i < DEPTH; i++)
            begin
                slot_busy[i]    = 1'b0;
                slot_pid[i]     = '0;
                slot_est[i]     = '0;
                slot_arrival[i] = '0;
                slot_seq[i]     = '0;
            end
            results_due.delete();
            err_count  = 0;
            mismatches <= 0;
            pending    <= 0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                if (cfg_index == CFG_POLICY_MODE)
                    policy = cfg_wr_data[0];
                else if (cfg_index == CFG_ALPHA)
                    alpha = cfg_wr_data;
            end

            if (m_tvalid && m_tready)
            begin
                got.status = m_tuser;
                got.pid    = m_tdata[M_PID_LSB +: PID_W];
                got.est    = m_tdata[M_EST_LSB +: EST_W];
                got.occ    = m_tdata[M_OCC_LSB +: OCC_W];
                if (results_due.size() == 0)
                begin
                    err_count++;
                    if (err_count <= 10)
                        $display("%0t: unexpected result: status=%0d pid=%h est=%h occ=%0d",
                                 $realtime, got.status, got.pid, got.est, got.occ);
                end
                else
                begin
                    want = results_due.pop_front();
                    if (got !== want)
                    begin
                        err_count++;
                        if (err_count <= 10)
                        begin
                            $write("%0t: mismatch: expected status=%0d pid=%h est=%h occ=%0d,",
                                   $realtime, want.status, want.pid, want.est, want.occ);
                            $display(" got status=%0d pid=%h est=%h occ=%0d",
                                     got.status, got.pid, got.est, got.occ);
                        end
                    end
                end
            end

            if (s_tvalid && s_tready)
                results_due.push_back(apply_request(s_tuser, s_tdata));

            mismatches <= err_count;
            pending    <= results_due.size();
        end
    end

endmodule

// File: tb/sv/tb_hrrn_fifo_ready_queue_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_hrrn_fifo_ready_queue_top
// Drives the ready-queue scheduler with a directed opening sequence and then
// random enqueue, dequeue, tick and unused-code transactions under several policy and
// smoothing settings, with random stalls on both streams. A checker beside
// the block predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_hrrn_fifo_ready_queue_top;

    import hfrq_pkg::*;

    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int SETTLE_TICKS = 100;
    localparam int PHASES       = 8;
    localparam int PHASE_ITEMS  = 240;

    logic                  clk;
    logic                  rst_n       = 1'b0;
    logic                  cfg_wr_en   = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index   = '0;
    logic [ALPHA_W-1:0]    cfg_wr_data = '0;
    logic                  s_tvalid    = 1'b0;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata     = '0;
    logic [OP_W-1:0]       s_tuser     = '0;
    logic                  m_tvalid;
    logic                  m_tready    = 1'b0;
    logic [M_TDATA_W-1:0]  m_tdata;
    logic [STATUS_W-1:0]   m_tuser;

    int                    mismatches;
    int                    pending;
    int                    cycle_count = 0;
    bit                    calm        = 1'b0;

    // Per-phase settings: policy, smoothing weight and request mix.
    int phase_policy [PHASES] = '{0, 1, 1, 0, 1, 1, 0, 1};
    int phase_alpha  [PHASES] = '{128, 0, 256, 511, 1, -1, -1, 255};
    int phase_enq    [PHASES] = '{45, 55, 35, 50, 60, 40, 45, 50};
    int phase_deq    [PHASES] = '{35, 25, 45, 30, 20, 40, 35, 30};

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    hrrn_fifo_ready_queue_top #(
        .QUEUE_DEPTH (QUEUE_DEPTH_DEF)
    ) dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser)
    );

    hfrq_sched_checker #(
        .DEPTH (QUEUE_DEPTH_DEF)
    ) u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .mismatches  (mismatches),
        .pending     (pending)
    );

    // Watchdog on total run length.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    // Result side stalls at random, except during the calm phase.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_tready <= 1'b0;
        else
            m_tready <= calm || ($urandom_range(0, 99) >= 18);
    end

    // Sends one request, after an occasional random gap outside the calm phase, and returns at its acceptance edge.
    task automatic send_item(logic [OP_W-1:0] op, logic [PID_W-1:0] pid,
                             logic [EST_W-1:0] est, logic [EST_W-1:0] run_time,
                             logic reest);
        logic [S_TDATA_W-1:0] d;
        d = '0;
        d[S_PID_LSB +: PID_W]  = pid;
        d[S_EST_LSB +: EST_W]  = est;
        d[S_REAL_LSB +: EST_W] = run_time;
        d[S_REEST_BIT]         = reest;
        if (!calm && $urandom_range(0, 99) < 18)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= d;
        s_tuser  <= op;
        do
            @(posedge clk);
        while (!s_tready);
    endtask

    // Holds off the sender until every outstanding result has arrived.
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (pending != 0);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [ALPHA_W-1:0] value);
        cfg_wr_en   <= 1'b1;
        cfg_index   <= idx;
        cfg_wr_data <= value;
        @(posedge clk);
    endtask

    // Estimates lean small so that ratios, zero estimates and ties are common.
    function automatic logic [EST_W-1:0] pick_estimate();
        case ($urandom_range(0, 2))
            0:       return EST_W'($urandom_range(0, 15));
            1:       return EST_W'($urandom_range(0, 300));
            default: return EST_W'($urandom_range(0, 65535));
        endcase
    endfunction

    task automatic random_item(int enq_pct, int deq_pct);
        int               pick;
        logic [OP_W-1:0]  op;
        pick = $urandom_range(0, 99);
        if (pick < enq_pct)
            op = OP_ENQUEUE;
        else if (pick < enq_pct + deq_pct)
            op = OP_DEQUEUE;
        else if (pick < 97)
            op = OP_TICK;
        else
            op = OP_UNUSED;
        send_item(op, PID_W'($urandom_range(0, 65535)), pick_estimate(),
                  ($urandom_range(0, 1) != 0) ? EST_W'($urandom_range(0, 65535))
                                              : EST_W'($urandom_range(0, 40)),
                  1'($urandom_range(0, 1)));
    endtask

    initial
    begin
        int alpha_val;

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // Directed opening under reset settings: empty dequeue, unused code,
        // tick, field extremes with smoothing, then fill the queue past full.
        send_item(OP_DEQUEUE, 16'h0000, 16'h0000, 16'h0000, 1'b0);
        send_item(OP_UNUSED,  16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1);
        send_item(OP_TICK,    16'h0000, 16'h0000, 16'h0000, 1'b0);
        send_item(OP_ENQUEUE, 16'hFFFF, 16'hFFFF, 16'h0000, 1'b1);
        send_item(OP_ENQUEUE, 16'h0000, 16'h0000, 16'hFFFF, 1'b1);
        send_item(OP_ENQUEUE, 16'h1234, 16'hFFFF, 16'hFFFF, 1'b0);
        for (int i = 0; i < QUEUE_DEPTH_DEF - 3; i++)
            send_item(OP_ENQUEUE, PID_W'(16'h0100 + i), EST_W'(i % 4), EST_W'(i), 1'b0);
        send_item(OP_ENQUEUE, 16'hA5A5, 16'h0007, 16'h5A5A, 1'b1);
        send_item(OP_DEQUEUE, 16'h0000, 16'h0000, 16'h0000, 1'b0);
        send_item(OP_TICK,    16'h0000, 16'h0000, 16'h0000, 1'b0);

        // Random phases, each under its own register settings.
        for (int ph = 0; ph < PHASES; ph++)
        begin
            wait_drained();
            alpha_val = (phase_alpha[ph] < 0) ? $urandom_range(0, 256) : phase_alpha[ph];
            write_reg(CFG_POLICY_MODE,
                      (phase_policy[ph] != 0) ? ALPHA_W'(MODE_HRRN) : ALPHA_W'(MODE_FIFO));
            write_reg(CFG_ALPHA, ALPHA_W'(alpha_val));
            cfg_wr_en <= 1'b0;
            calm      <= (ph == 3);
            @(posedge clk);
            for (int k = 0; k < PHASE_ITEMS; k++)
            begin
                if (k == PHASE_ITEMS / 2)
                    wait_drained();
                random_item(phase_enq[ph], phase_deq[ph]);
            end
        end

        wait_drained();
        repeat (SETTLE_TICKS) @(posedge clk);
        if (mismatches == 0 && pending == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

// File: filelist.f
rtl/hfrq_pkg.sv
rtl/hfrq_ram.sv
rtl/hrrn_fifo_ready_queue_top.sv
rtl/hfrq_checker.sv
tb/sv/hfrq_sched_checker.sv
tb/sv/tb_hrrn_fifo_ready_queue_top.sv
